>>> rtl/spkv_pkg.sv
package spkv_pkg;

  // Field geometry
  localparam int unsigned INDEX_BITS       = 10;
  localparam int unsigned KEY_W            = 3 * INDEX_BITS;
  localparam int unsigned VALUE_W          = 64;
  localparam int unsigned COUNT_W          = 9;
  localparam int unsigned CMD_W            = 2;
  localparam int unsigned DEFAULT_CAPACITY = 256;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [INDEX_BITS-1:0] index_l;
    logic [INDEX_BITS-1:0] index_m;
    logic [INDEX_BITS-1:0] index_p;
    logic [VALUE_W-1:0]    write_value;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] entry_count;
    logic               full_flag;
  } out_word_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_LAST,
    ST_CHECK_LAST,
    ST_APPEND,
    ST_SEARCH,
    ST_SEARCH_CMP,
    ST_PROBE_CMP,
    ST_SHIFT_FIRST,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_INSERT,
    ST_FINISH
  } state_e;

  // Memory read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_LAST,
    RD_MID,
    RD_LO,
    RD_SHIFT
  } rd_sel_e;

  // Memory write select
  typedef enum logic [2:0] {
    WR_NONE,
    WR_PIPE,
    WR_TAIL,
    WR_AT_COUNT,
    WR_AT_LO
  } wr_sel_e;

  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    search_init;
    logic    search_step;
    logic    shift_init;
    logic    shift_step;
    logic    count_inc;
    logic    count_clr;
    logic    set_found;
    logic    set_full;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             count_zero;
    logic             count_full;
    logic             key_gt_rd;
    logic             key_eq_rd;
    logic             lo_lt_hi;
    logic             lo_lt_count;
    logic             sh_at_lo;
    logic             out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/spkv_datapath.sv
module spkv_datapath #(
  parameter int unsigned CAPACITY = spkv_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spkv_pkg::in_word_t  in_word_i,
  input  spkv_pkg::ctrl_cmd_t cmd_i,
  output spkv_pkg::ctrl_sts_t sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output spkv_pkg::out_word_t out_word_o
);
  import spkv_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Storage
  logic [KEY_W-1:0]   key_mem [CAPACITY];
  logic [VALUE_W-1:0] val_mem [CAPACITY];

  // Captured word
  logic [CMD_W-1:0]   cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]      sh_q, sh_d;
  logic [KEY_W-1:0]   rd_key_q;
  logic [VALUE_W-1:0] rd_val_q;
  logic               found_q, full_q;
  logic               out_valid_q;
  out_word_t          out_word_q;

  logic [CW:0]        lo_hi_sum;
  logic [CW-1:0]      mid;
  logic [AW-1:0]      last_addr;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               rd_en, wr_en;
  logic [KEY_W-1:0]   wr_key;
  logic [VALUE_W-1:0] wr_val;
  logic [CW+COUNT_W-1:0] count_ext;

  // Search midpoint and tail address
  assign lo_hi_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
  assign mid       = lo_hi_sum[CW:1];
  assign last_addr = AW'(count_q - CW'(1));

  // Read address select
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd_i.rd_sel)
      RD_LAST:  rd_addr = last_addr;
      RD_MID:   rd_addr = mid[AW-1:0];
      RD_LO:    rd_addr = lo_q[AW-1:0];
      RD_SHIFT: rd_addr = sh_q;
      default:  rd_en   = 1'b0;
    endcase
  end

  // Write address and data select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_key  = key_q;
    wr_val  = val_q;
    case (cmd_i.wr_sel)
      WR_PIPE: begin
        wr_addr = sh_q + AW'(1) + AW'(1);
        wr_key  = rd_key_q;
        wr_val  = rd_val_q;
      end
      WR_TAIL: begin
        wr_addr = sh_q + AW'(1);
        wr_key  = rd_key_q;
        wr_val  = rd_val_q;
      end
      WR_AT_COUNT: wr_addr = count_q[AW-1:0];
      WR_AT_LO:    wr_addr = lo_q[AW-1:0];
      default:     wr_en   = 1'b0;
    endcase
  end

  // Key and value memories, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
    end
  end

  // Search bounds and shift pointer
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    sh_d = sh_q;
    if (cmd_i.search_init) begin
      lo_d = '0;
      hi_d = count_q;
    end else if (cmd_i.search_step) begin
      if (rd_key_q < key_q) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
    end
    if (cmd_i.shift_init) begin
      sh_d = last_addr;
    end else if (cmd_i.shift_step) begin
      sh_d = sh_q - AW'(1);
    end
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.count_clr) begin
      count_d = '0;
    end else if (cmd_i.count_inc) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    sh_q <= sh_d;
    if (cmd_i.capture) begin
      cmd_q <= in_word_i.command;
      key_q <= {in_word_i.index_l, in_word_i.index_m, in_word_i.index_p};
      val_q <= in_word_i.write_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      found_q <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.capture) begin
        found_q <= 1'b0;
        full_q  <= 1'b0;
      end else begin
        if (cmd_i.set_found) found_q <= 1'b1;
        if (cmd_i.set_full)  full_q  <= 1'b1;
      end
    end
  end

  // Output register
  assign count_ext = (CW+COUNT_W)'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_word_q.found       <= found_q;
      out_word_q.read_value  <= found_q ? rd_val_q : '0;
      out_word_q.entry_count <= count_ext[COUNT_W-1:0];
      out_word_q.full_flag   <= full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Status to the sequencer
  assign sts_o.cmd         = cmd_q;
  assign sts_o.count_zero  = (count_q == '0);
  assign sts_o.count_full  = (count_q == CW'(CAPACITY));
  assign sts_o.key_gt_rd   = (key_q > rd_key_q);
  assign sts_o.key_eq_rd   = (key_q == rd_key_q);
  assign sts_o.lo_lt_hi    = (lo_q < hi_q);
  assign sts_o.lo_lt_count = (lo_q < count_q);
  assign sts_o.sh_at_lo    = (CW'(sh_q) == lo_q);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

>>> rtl/spkv_controller.sv
module spkv_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spkv_pkg::ctrl_sts_t sts_i,
  output spkv_pkg::ctrl_cmd_t cmd_o
);
  import spkv_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_NONE;
    cmd_o.wr_sel = WR_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.cmd)
          CMD_SET: begin
            state_d = sts_i.count_zero ? ST_APPEND : ST_READ_LAST;
          end
          CMD_GET: begin
            cmd_o.search_init = 1'b1;
            state_d           = sts_i.count_zero ? ST_FINISH : ST_SEARCH;
          end
          CMD_CLEAR: begin
            cmd_o.count_clr = 1'b1;
            state_d         = ST_FINISH;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_READ_LAST: begin
        cmd_o.rd_sel = RD_LAST;
        state_d      = ST_CHECK_LAST;
      end
      // Key beyond the tail appends (or is dropped when full), otherwise search
      ST_CHECK_LAST: begin
        if (sts_i.key_gt_rd) begin
          if (sts_i.count_full) begin
            cmd_o.set_full = 1'b1;
            state_d        = ST_FINISH;
          end else begin
            state_d = ST_APPEND;
          end
        end else begin
          cmd_o.search_init = 1'b1;
          state_d           = ST_SEARCH;
        end
      end
      ST_APPEND: begin
        cmd_o.wr_sel    = WR_AT_COUNT;
        cmd_o.count_inc = 1'b1;
        state_d         = ST_FINISH;
      end
      // Lower-bound search; each probe reads the midpoint, then narrows the bounds
      ST_SEARCH: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.rd_sel = RD_MID;
          state_d      = ST_SEARCH_CMP;
        end else if (sts_i.lo_lt_count) begin
          cmd_o.rd_sel = RD_LO;
          state_d      = ST_PROBE_CMP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SEARCH_CMP: begin
        cmd_o.search_step = 1'b1;
        state_d           = ST_SEARCH;
      end
      ST_PROBE_CMP: begin
        if (sts_i.key_eq_rd) begin
          if (sts_i.cmd == CMD_SET) begin
            cmd_o.wr_sel = WR_AT_LO;
          end else begin
            cmd_o.set_found = 1'b1;
          end
          state_d = ST_FINISH;
        end else if (sts_i.cmd != CMD_SET) begin
          state_d = ST_FINISH;
        end else if (sts_i.count_full) begin
          cmd_o.set_full = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT_FIRST;
        end
      end
      // Move entries up from the tail down to the insert point
      ST_SHIFT_FIRST: begin
        cmd_o.rd_sel = RD_SHIFT;
        if (sts_i.sh_at_lo) begin
          state_d = ST_SHIFT_END;
        end else begin
          cmd_o.shift_step = 1'b1;
          state_d          = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.rd_sel = RD_SHIFT;
        cmd_o.wr_sel = WR_PIPE;
        if (sts_i.sh_at_lo) begin
          state_d = ST_SHIFT_END;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      ST_SHIFT_END: begin
        cmd_o.wr_sel = WR_TAIL;
        state_d      = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.wr_sel    = WR_AT_LO;
        cmd_o.count_inc = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/sorted_packed_key_value_table.sv
// Sorted key/value table. Keys are {index_l, index_m, index_p} (30 bits) kept
// in ascending order in a single-port-write, registered-read memory of
// CAPACITY entries; values are 64-bit patterns. One word is processed at a
// time: input is stalled from acceptance until the result is placed in the
// output register, and the next word may be taken while that result waits.
// Per word: a lookup is a lower-bound search of memory probes plus one
// confirming probe; a set on a non-empty table first checks the tail and
// appends when the key is above it, else searches the same way; an insert
// then moves the later entries up through the single read port, one entry
// per cycle. No clearing pass after reset.
module sorted_packed_key_value_table #(
  parameter int unsigned CAPACITY = spkv_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spkv_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spkv_pkg::out_word_t out_word_o
);
  import spkv_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  spkv_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  spkv_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (ctrl_sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

>>> rtl/spkv_checker.sv
module spkv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input spkv_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input spkv_pkg::out_word_t out_word_o
);
  import spkv_pkg::*;

  // Held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // Offered input word stays put while stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed while stalled");

  // A hit never reports a dropped set
  a_found_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.found && out_word_o.full_flag))
    else $error("found and full_flag both set");

  // Miss or non-lookup returns a zero value
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |-> out_word_o.read_value == '0)
    else $error("read_value nonzero without a hit");

  // Accepted word keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

endmodule

bind sorted_packed_key_value_table spkv_checker u_spkv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

>>> verif/tb_sorted_packed_key_value_table.sv
module tb_sorted_packed_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  import spkv_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEFAULT_CAPACITY;
  localparam int unsigned RESET_CYCLES = 6;
  // Longest word: lookup search plus moving every later entry.
  // A long receiver hold-off and stall bursts stack on top; the limit is well above both together.
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned WORD_TARGET  = 850;
  localparam int unsigned CALM_TAIL    = 100;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MIN    = '0;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  // Shadow copy of the table: predicts one reply per accepted word
  class sorted_table_shadow;
    logic [KEY_W-1:0]   keys   [TABLE_DEPTH];
    logic [VALUE_W-1:0] values [TABLE_DEPTH];
    int unsigned        entries;
    out_word_t          expected_replies [$];
    int unsigned        mismatches;

    function void apply_command(in_word_t w);
      out_word_t        reply;
      logic [KEY_W-1:0] key;
      int unsigned      pos;
      int               i;
      key   = {w.index_l, w.index_m, w.index_p};
      reply = '0;
      // lower bound: first slot whose key is not below the new one
      pos = 0;
      while (pos < entries && keys[pos] < key) pos++;
      case (w.command)
        CMD_SET: begin
          if (pos < entries && keys[pos] == key) begin
            values[pos] = w.write_value;
          end else if (entries == TABLE_DEPTH) begin
            reply.full_flag = 1'b1;
          end else begin
            for (i = int'(entries); i > int'(pos); i--) begin
              keys[i]   = keys[i-1];
              values[i] = values[i-1];
            end
            keys[pos]   = key;
            values[pos] = w.write_value;
            entries++;
          end
        end
        CMD_GET: begin
          if (pos < entries && keys[pos] == key) begin
            reply.found      = 1'b1;
            reply.read_value = values[pos];
          end
        end
        CMD_CLEAR: entries = 0;
        default: ;
      endcase
      reply.entry_count = COUNT_W'(entries);
      expected_replies = {expected_replies, reply};
    endfunction

    function void compare_reply(out_word_t got);
      out_word_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with no command outstanding: %p", got);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
      if (got.full_flag !== want.full_flag) begin
        $error("full_flag: expected %0d, actual %0d", want.full_flag, got.full_flag);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  sorted_table_shadow shadow;
  bit                 idling_on    = 1'b0;
  bit                 hold_off_req = 1'b0;
  int unsigned        words_sent   = 0;
  int unsigned        quiet_cycles = 0;

  sorted_packed_key_value_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #2 clk_i = ~clk_i;

  // Random field helpers
  function automatic logic [INDEX_BITS-1:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return INDEX_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_fresh_key();
    return {pick_index(), pick_index(), pick_index()};
  endfunction

  function automatic logic [KEY_W-1:0] pick_stored_key();
    if (shadow.entries == 0) return pick_fresh_key();
    return shadow.keys[$urandom_range(0, shadow.entries - 1)];
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_word_t make_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                         logic [VALUE_W-1:0] value);
    in_word_t w;
    w.command                       = cmd;
    {w.index_l, w.index_m, w.index_p} = key;
    w.write_value                   = value;
    return w;
  endfunction

  // Offer one word and hold it until accepted; valid stays high for the caller
  task automatic send_word(in_word_t w);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    shadow.apply_command(w);
    if (w.command != CMD_UNUSED) words_sent++;
  endtask

  // Stop offering and wait until every outstanding reply has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shadow.expected_replies.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall    <= 1'b0;
        hold_off_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Reply monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) shadow.compare_reply(out_word);
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned next_key;
    int unsigned fill_steps;
    shadow = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling_on = 1'b1;

    // Directed: empty table, key extremes, front and middle inserts, update at tail
    send_word(make_word(CMD_GET,    KEY_MIN,          '1));
    send_word(make_word(CMD_SET,    KEY_MAX,          '1));
    send_word(make_word(CMD_SET,    KEY_MIN,          '0));
    send_word(make_word(CMD_SET,    {10'd512, 10'd0, 10'd1}, 64'haaaa_aaaa_aaaa_aaaa));
    send_word(make_word(CMD_SET,    30'd1,            64'h5555_5555_5555_5555));
    send_word(make_word(CMD_GET,    KEY_MAX,          '0));
    send_word(make_word(CMD_GET,    KEY_MIN,          '1));
    send_word(make_word(CMD_GET,    {10'd512, 10'd0, 10'd1}, '0));
    send_word(make_word(CMD_GET,    {10'd512, 10'd0, 10'd0}, '0));
    send_word(make_word(CMD_SET,    KEY_MAX,          64'h0123_4567_89ab_cdef));
    send_word(make_word(CMD_GET,    KEY_MAX,          '0));
    send_word(make_word(CMD_SET,    KEY_MAX - 1'b1,   64'hfedc_ba98_7654_3210));
    send_word(make_word(CMD_UNUSED, pick_fresh_key(), pick_value()));
    send_word(make_word(CMD_GET,    KEY_MAX - 1'b1,   '0));
    send_word(make_word(CMD_GET,    30'd1,            '0));
    send_word(make_word(CMD_CLEAR,  KEY_MAX,          '1));
    send_word(make_word(CMD_GET,    KEY_MAX,          '0));
    send_word(make_word(CMD_SET,    KEY_MIN,          64'h8000_0000_0000_0001));
    send_word(make_word(CMD_UNUSED, KEY_MAX,          '1));
    send_word(make_word(CMD_GET,    KEY_MIN,          '0));

    // Fill to capacity, mostly in-order appends; receiver holds off part way
    wait_drained();
    send_word(make_word(CMD_CLEAR, pick_fresh_key(), pick_value()));
    next_key   = $urandom_range(0, 1000);
    fill_steps = 0;
    while (shadow.entries < TABLE_DEPTH) begin
      fill_steps++;
      if (fill_steps == 100) hold_off_req = 1'b1;
      case ($urandom_range(0, 9))
        0: send_word(make_word(CMD_SET, pick_fresh_key(), pick_value()));
        1: send_word(make_word(CMD_GET, pick_stored_key(), pick_value()));
        default: begin
          next_key = next_key + $urandom_range(1, 4000000);
          send_word(make_word(CMD_SET, KEY_W'(next_key), pick_value()));
        end
      endcase
    end

    // Full table: dropped appends and inserts, in-place updates, lookups
    repeat (40) begin
      case ($urandom_range(0, 5))
        0: send_word(make_word(CMD_SET, KEY_MAX, pick_value()));
        1: send_word(make_word(CMD_SET, pick_fresh_key(), pick_value()));
        2: send_word(make_word(CMD_SET, pick_stored_key(), pick_value()));
        3, 4: send_word(make_word(CMD_GET, pick_stored_key(), pick_value()));
        default: send_word(make_word(CMD_GET, pick_fresh_key(), pick_value()));
      endcase
    end

    // Mixed traffic; clears are rare so the table grows deep
    wait_drained();
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= WORD_TARGET - CALM_TAIL) idling_on = 1'b0;
      case ($urandom_range(0, 99)) inside
        [0:21]:  send_word(make_word(CMD_SET, pick_stored_key(), pick_value()));
        [22:44]: send_word(make_word(CMD_SET, pick_fresh_key(), pick_value()));
        [45:74]: send_word(make_word(CMD_GET, pick_stored_key(), pick_value()));
        [75:94]: send_word(make_word(CMD_GET, pick_fresh_key(), pick_value()));
        95:      send_word(make_word(CMD_CLEAR, pick_fresh_key(), pick_value()));
        default: send_word(make_word(CMD_UNUSED, pick_fresh_key(), pick_value()));
      endcase
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
